// ===== rtl/pidc_pkg.sv =====
`default_nettype none

package pidc_pkg;

    // field widths
    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 31;
    localparam int TERM_W     = 32;
    localparam int SUM_W      = 34;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // control tick rate in samples per second
    localparam int SAMPLE_RATE = 250;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_PROP_LIMIT  = 3'd3,
        CFG_INTEG_LIMIT = 3'd4,
        CFG_DERIV_LIMIT = 3'd5
    } cfg_reg_t;

    // datapath widths
    localparam int DIFF_W   = ERR_W + 1;
    localparam int PPROD_W  = ERR_W + GAIN_W + 1;
    localparam int DPROD_W  = DIFF_W + GAIN_W + 1;
    localparam int RATE_W   = $clog2(SAMPLE_RATE + 1) + 1;
    localparam int DSCALE_W = DPROD_W + RATE_W;
    localparam int CLAMP_W  = DSCALE_W - FRAC_W;
    localparam int Q_W      = PPROD_W - FRAC_W;

    localparam logic signed [RATE_W-1:0] RATE_S = RATE_W'(SAMPLE_RATE);
    localparam logic [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

    // floor division by the rate: bias to a non-negative numerator, then
    // multiply by a rounded-up reciprocal and shift
    localparam int BIAS_LOG    = ERR_W - 1 + GAIN_W - FRAC_W;
    localparam int NUM_W       = BIAS_LOG + 2;
    localparam int RATE_LOG    = $clog2(SAMPLE_RATE);
    localparam int RECIP_SHIFT = NUM_W + RATE_LOG;
    localparam int RECIP_W     = NUM_W + 1;
    localparam int SPLIT       = (NUM_W + 1) / 2;
    localparam int NUM_HI_W    = NUM_W - SPLIT;
    localparam int RECIP_HI_W  = RECIP_W - SPLIT;
    localparam int FULL_W      = NUM_W + RECIP_W;

    localparam logic [63:0] RATE_64   = 64'(SAMPLE_RATE);
    localparam logic [63:0] RECIP_64  = ((64'd1 << RECIP_SHIFT) + RATE_64 - 64'd1) / RATE_64;
    localparam logic [63:0] BIAS_Q_64 = ((64'd1 << BIAS_LOG) + RATE_64 - 64'd1) / RATE_64;

    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_64);
    localparam logic [NUM_W-1:0]   BIAS   = NUM_W'(BIAS_Q_64 * RATE_64);
    localparam logic [Q_W-1:0]     BIAS_Q = Q_W'(BIAS_Q_64);

    // load strobes of the divider stages
    typedef struct packed {
        logic load_parts;
        logic load_quot;
    } div_ctrl_t;

    // symmetric saturation to +/- lim
    function automatic logic signed [TERM_W-1:0] clamp_sym(
        input logic signed [CLAMP_W-1:0] v,
        input logic [LIMIT_W-1:0]        lim
    );
        logic signed [CLAMP_W-1:0] pos;
        logic signed [CLAMP_W-1:0] neg;
        logic signed [CLAMP_W-1:0] res;
        pos = $signed(CLAMP_W'(lim));
        neg = -pos;
        if (v > pos)
        begin
            res = pos;
        end
        else if (v < neg)
        begin
            res = neg;
        end
        else
        begin
            res = v;
        end
        return TERM_W'(res);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pidc_rate_div.sv =====
`default_nettype none

module pidc_rate_div (
    input  wire                              clk,
    input  wire [pidc_pkg::NUM_W-1:0]        num,
    input  wire pidc_pkg::div_ctrl_t         ctrl,
    output logic signed [pidc_pkg::Q_W-1:0]  quot
);
    import pidc_pkg::*;

    localparam int LL_W = 2 * SPLIT;
    localparam int LH_W = SPLIT + RECIP_HI_W;
    localparam int HL_W = NUM_HI_W + SPLIT;
    localparam int HH_W = NUM_HI_W + RECIP_HI_W;

    localparam logic [SPLIT-1:0]      RECIP_LO = RECIP[SPLIT-1:0];
    localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:SPLIT];

    logic [SPLIT-1:0]    num_lo;
    logic [NUM_HI_W-1:0] num_hi;

    logic [LL_W-1:0] ll_reg, ll_next;
    logic [LH_W-1:0] lh_reg, lh_next;
    logic [HL_W-1:0] hl_reg, hl_next;
    logic [HH_W-1:0] hh_reg, hh_next;

    logic [FULL_W-1:0]        full;
    logic signed [Q_W-1:0]    quot_reg, quot_next;

    // partial products against the constant reciprocal
    assign num_lo  = num[SPLIT-1:0];
    assign num_hi  = num[NUM_W-1:SPLIT];
    assign ll_next = LL_W'(num_lo) * LL_W'(RECIP_LO);
    assign lh_next = LH_W'(num_lo) * LH_W'(RECIP_HI);
    assign hl_next = HL_W'(num_hi) * HL_W'(RECIP_LO);
    assign hh_next = HH_W'(num_hi) * HH_W'(RECIP_HI);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_parts)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
    end

    // recombine, drop the fraction and remove the bias
    assign full = (FULL_W'(hh_reg) << (2 * SPLIT))
                + (FULL_W'(hl_reg) << SPLIT)
                + (FULL_W'(lh_reg) << SPLIT)
                + FULL_W'(ll_reg);
    assign quot_next = $signed(Q_W'(full >> RECIP_SHIFT) - BIAS_Q);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_quot)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/pid_with_term_clamping.sv =====
`default_nettype none

// PID controller with per-term saturation, Q16.16 fixed point. Each error word
// yields one result word: the proportional, integral and derivative terms,
// each clamped to its own symmetric limit, and their 34-bit sum. The block is a
// seven-stage pipeline that takes one error word every clock unless in_stall is
// high; the depth is set by the three gain multipliers, the divide by SAMPLE_RATE
// (a reciprocal multiply split into registered partial products) and the final
// sum. A stalled output holds only the stages that are full, so empty stages keep
// taking words. The user must write gains and limits through the cfg port only
// while no word is in flight; the block does not enforce this. After reset the
// gain, limit and valid registers, the integrator and the previous error are zero.
module pid_with_term_clamping (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [pidc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire signed [pidc_pkg::ERR_W-1:0]     error_sample,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic signed [pidc_pkg::SUM_W-1:0]    correction,
    output logic signed [pidc_pkg::TERM_W-1:0]   prop_term,
    output logic signed [pidc_pkg::TERM_W-1:0]   integ_term,
    output logic signed [pidc_pkg::TERM_W-1:0]   deriv_term
);
    import pidc_pkg::*;

    localparam int STAGES = 7;

    // configuration
    logic [GAIN_W-1:0]  prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [LIMIT_W-1:0] prop_limit_reg, integ_limit_reg, deriv_limit_reg;

    // pipeline control
    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] feed;
    logic [STAGES-1:0] stage_en;
    logic [STAGES-1:0] load;

    // state
    logic signed [ERR_W-1:0]  prev_error_reg;
    logic signed [TERM_W-1:0] integ_accum_reg;
    logic signed [TERM_W-1:0] accum_next;

    // stage 0
    logic signed [ERR_W-1:0]  err0_reg;
    logic signed [DIFF_W-1:0] diff0_reg;
    // stage 1
    logic signed [PPROD_W-1:0] pprod1_reg, iprod1_reg;
    logic signed [DPROD_W-1:0] dprod1_reg;
    // stage 2
    logic signed [DSCALE_W-1:0] dscale;
    logic signed [TERM_W-1:0]   prop2_reg, deriv2_reg;
    logic [NUM_W-1:0]           num2_reg;
    // stages 3 and 4
    logic signed [TERM_W-1:0] prop3_reg, deriv3_reg, prop4_reg, deriv4_reg;
    div_ctrl_t                div_ctrl;
    logic signed [Q_W-1:0]    div_quot;
    // stage 5
    logic signed [TERM_W-1:0] prop5_reg, integ5_reg, deriv5_reg;
    // output stage
    logic signed [SUM_W-1:0]  correction_reg;
    logic signed [TERM_W-1:0] prop_out_reg, integ_out_reg, deriv_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            prop_limit_reg  <= '0;
            integ_limit_reg <= '0;
            deriv_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_PROP_LIMIT:  prop_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_DERIV_LIMIT: deriv_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage advances when it is empty or the next one advances
    always_comb
    begin
        stage_en[6] = !valid_reg[6] || !out_stall;
        stage_en[5] = !valid_reg[5] || stage_en[6];
        stage_en[4] = !valid_reg[4] || stage_en[5];
        stage_en[3] = !valid_reg[3] || stage_en[4];
        stage_en[2] = !valid_reg[2] || stage_en[3];
        stage_en[1] = !valid_reg[1] || stage_en[2];
        stage_en[0] = !valid_reg[0] || stage_en[1];
    end

    assign feed       = {valid_reg[STAGES-2:0], in_valid};
    assign load       = stage_en & feed;
    assign valid_next = (stage_en & feed) | (~stage_en & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 0: capture the word and the error difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
        end
        else if (load[0])
        begin
            prev_error_reg <= error_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            err0_reg  <= error_sample;
            diff0_reg <= DIFF_W'(error_sample) - DIFF_W'(prev_error_reg);
        end
    end

    // stage 1: gain products
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            pprod1_reg <= err0_reg * $signed({1'b0, prop_gain_reg});
            iprod1_reg <= err0_reg * $signed({1'b0, integ_gain_reg});
            dprod1_reg <= diff0_reg * $signed({1'b0, deriv_gain_reg});
        end
    end

    // stage 2: scale the derivative by the rate, truncate to Q16.16, clamp, bias the integral increment
    assign dscale = dprod1_reg * RATE_S;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            prop2_reg  <= clamp_sym(CLAMP_W'(pprod1_reg >>> FRAC_W), prop_limit_reg);
            deriv2_reg <= clamp_sym(CLAMP_W'(dscale >>> FRAC_W), deriv_limit_reg);
            num2_reg   <= NUM_W'(iprod1_reg >>> FRAC_W) + BIAS;
        end
    end

    // stages 3 and 4: floor divide by the rate
    assign div_ctrl.load_parts = load[3];
    assign div_ctrl.load_quot  = load[4];

    pidc_rate_div u_rate_div (
        .clk  (clk),
        .num  (num2_reg),
        .ctrl (div_ctrl),
        .quot (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            prop3_reg  <= prop2_reg;
            deriv3_reg <= deriv2_reg;
        end
        if (load[4])
        begin
            prop4_reg  <= prop3_reg;
            deriv4_reg <= deriv3_reg;
        end
    end

    // stage 5: integrator update with saturation
    assign accum_next = clamp_sym(CLAMP_W'(integ_accum_reg) + CLAMP_W'(div_quot),
                                  integ_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_accum_reg <= '0;
        end
        else if (load[5])
        begin
            integ_accum_reg <= accum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            prop5_reg  <= prop4_reg;
            deriv5_reg <= deriv4_reg;
            integ5_reg <= (integ_gain_reg == '0) ? '0 : accum_next;
        end
    end

    // output stage: sum of the three terms
    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            correction_reg <= SUM_W'(prop5_reg) + SUM_W'(integ5_reg) + SUM_W'(deriv5_reg);
            prop_out_reg   <= prop5_reg;
            integ_out_reg  <= integ5_reg;
            deriv_out_reg  <= deriv5_reg;
        end
    end

    assign in_stall   = !stage_en[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign correction = correction_reg;
    assign prop_term  = prop_out_reg;
    assign integ_term = integ_out_reg;
    assign deriv_term = deriv_out_reg;

    // input backs up only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the pipeline has room");

    // clamped terms never reach the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (prop_term != TERM_MIN && integ_term != TERM_MIN
                       && deriv_term != TERM_MIN))
        else $error("term outside its symmetric range");

    // integrator stays inside its symmetric range
    assert property (@(posedge clk) disable iff (!rst_n)
        integ_accum_reg != TERM_MIN)
        else $error("integrator outside its symmetric range");

endmodule

`default_nettype wire
